>>> rtl/deq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the double-ended queue unit.
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_WIDTH    = 32;
    localparam int OCC_WIDTH     = 5;

    localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [1:0] CMD_POP_BACK   = 2'd2;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                   command;
        logic signed [WORD_WIDTH-1:0] element;
    } deq_req_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] value;
        logic [1:0]                   status;
        logic [OCC_WIDTH-1:0]         occupancy;
    } deq_resp_t;

    typedef struct packed {
        logic load;
        logic capture;
    } deq_ctrl_t;

    typedef struct packed {
        logic pop_read;
    } deq_stat_t;

endpackage

>>> rtl/deq_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/deq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the queue: ring pointers, occupancy count, store and result register.
module deq_datapath
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  deq_req_t  req,
    input  deq_ctrl_t ctrl,
    output deq_stat_t stat,
    output deq_resp_t resp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [AW:0]   DEPTH_SUM  = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic signed [WORD_WIDTH-1:0] value_reg, value_next;
    logic [1:0]           status_reg, status_next;
    logic [OCC_WIDTH-1:0] occ_reg, occ_next;

    logic          full, empty, ok, ram_we;
    logic [AW:0]   back_sum, last_sum, front_sum;
    logic [AW-1:0] back_slot, last_slot, front_inc, front_dec, ram_addr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    assign full  = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);

    assign back_sum  = (AW + 1)'(front_reg) + (AW + 1)'(count_reg);
    assign last_sum  = back_sum - (AW + 1)'(1);
    assign front_sum = (AW + 1)'(front_reg) + (AW + 1)'(1);

    assign back_slot = (back_sum >= DEPTH_SUM) ? AW'(back_sum - DEPTH_SUM) : AW'(back_sum);
    assign last_slot = (last_sum >= DEPTH_SUM) ? AW'(last_sum - DEPTH_SUM) : AW'(last_sum);
    assign front_inc = (front_sum >= DEPTH_SUM) ? AW'(front_sum - DEPTH_SUM)
                                                : AW'(front_sum);
    assign front_dec = (front_reg == '0) ? LAST_INDEX : front_reg - AW'(1);

    always_comb begin
        ok          = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = front_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = STATUS_OK;
        case (req.command)
            CMD_PUSH_BACK: begin
                ram_addr = back_slot;
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ok         = 1'b1;
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                ram_addr = front_dec;
                if (full) begin
                    status_next = STATUS_FULL;
                end else begin
                    ok         = 1'b1;
                    ram_we     = 1'b1;
                    front_next = front_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_BACK: begin
                ram_addr = last_slot;
                if (empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    ok         = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                ram_addr = front_reg;
                if (empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    ok         = 1'b1;
                    front_next = front_inc;
                    count_next = count_reg - CW'(1);
                end
            end
        endcase
    end

    assign stat.pop_read = ok && req.command[1];
    assign occ_next      = OCC_WIDTH'(count_next);
    assign value_next    = ctrl.capture ? $signed(ram_rdata) : '0;

    deq_ram #(
        .WIDTH(WORD_WIDTH),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ctrl.load && ram_we),
        .addr (ram_addr),
        .wdata(req.element),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else if (ctrl.load) begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            status_reg <= status_next;
            occ_reg    <= occ_next;
        end
        if (ctrl.load || ctrl.capture) begin
            value_reg <= value_next;
        end
    end

    assign resp.value     = value_reg;
    assign resp.status    = status_reg;
    assign resp.occupancy = occ_reg;

endmodule

>>> rtl/deq_controller.sv
`timescale 1ns / 1ps
// Controller state machine that sequences one request at a time.
module deq_controller
    import deq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  deq_stat_t stat,
    output deq_ctrl_t ctrl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = stat.pop_read ? S_READ : S_RESP;
                end
            end
            S_READ: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_RESP);
    assign ctrl.load    = s_ready && s_valid;
    assign ctrl.capture = (state_reg == S_READ);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Double-ended queue unit: top level joining the controller and the datapath.
// One request is handled at a time. A push or a refused request presents its result in the
// cycle after acceptance; a pop passes through S_READ first to capture the store RAM read.
// A new request is accepted only after the result of the last one has been taken on m_ready.
// Reset is synchronous and active low; it empties the queue, the store keeps its data.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  deq_req_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output deq_resp_t m_payload
);

    deq_ctrl_t ctrl;
    deq_stat_t stat;

    deq_controller u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .ctrl   (ctrl)
    );

    deq_datapath #(
        .DEPTH(DEPTH)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (s_payload),
        .ctrl   (ctrl),
        .stat   (stat),
        .resp   (m_payload)
    );

endmodule
